[design/cscan_pkg.sv]
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types, microcode fields and the control program of the C-SCAN core.
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam int CylW  = 16;
  localparam int StepW = 4;

  // input commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // emit sources
  localparam logic [2:0] EM_NONE    = 3'd0;
  localparam logic [2:0] EM_HEAD    = 3'd1;
  localparam logic [2:0] EM_BEST    = 3'd2;
  localparam logic [2:0] EM_BOUND_A = 3'd3;
  localparam logic [2:0] EM_BOUND_B = 3'd4;
  localparam logic [2:0] EM_FLUSH   = 3'd5;

  // phase control
  localparam logic [1:0] PH_KEEP  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_NEXT  = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEXT        = 3'd0;
  localparam logic [2:0] C_ALWAYS      = 3'd1;
  localparam logic [2:0] C_IF_NOT_RUN  = 3'd2;
  localparam logic [2:0] C_IF_SCANNING = 3'd3;
  localparam logic [2:0] C_IF_FOUND    = 3'd4;
  localparam logic [2:0] C_IF_PHASE1   = 3'd5;

  // program addresses
  localparam logic [StepW-1:0] S_IDLE    = 4'd0;
  localparam logic [StepW-1:0] S_HEAD    = 4'd1;
  localparam logic [StepW-1:0] S_INIT    = 4'd2;
  localparam logic [StepW-1:0] S_SCAN    = 4'd3;
  localparam logic [StepW-1:0] S_PICK    = 4'd4;
  localparam logic [StepW-1:0] S_BRANCH  = 4'd5;
  localparam logic [StepW-1:0] S_BOUND_A = 4'd6;
  localparam logic [StepW-1:0] S_BOUND_B = 4'd7;
  localparam logic [StepW-1:0] S_FIN     = 4'd8;

  typedef struct packed {
    logic             accept;
    logic [2:0]       emit;
    logic             scan_init;
    logic             scan;
    logic [1:0]       phase_op;
    logic [2:0]       cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic run_acc;
    logic scanning;
    logic found;
    logic phase1;
    logic stall;
  } status_t;

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{accept: 1'b0, emit: EM_NONE, scan_init: 1'b0, scan: 1'b0,
          phase_op: PH_KEEP, cond: C_NEXT, target: S_IDLE};
    unique case (step)
      S_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_IF_NOT_RUN;
        w.target = S_IDLE;
      end
      S_HEAD: begin
        w.emit     = EM_HEAD;
        w.phase_op = PH_START;
      end
      S_INIT: w.scan_init = 1'b1;
      S_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = C_IF_SCANNING;
        w.target = S_SCAN;
      end
      S_PICK: begin
        w.emit   = EM_BEST;
        w.cond   = C_IF_FOUND;
        w.target = S_INIT;
      end
      S_BRANCH: begin
        w.cond   = C_IF_PHASE1;
        w.target = S_FIN;
      end
      S_BOUND_A: w.emit = EM_BOUND_A;
      S_BOUND_B: begin
        w.emit     = EM_BOUND_B;
        w.phase_op = PH_NEXT;
        w.cond     = C_ALWAYS;
        w.target   = S_INIT;
      end
      S_FIN: begin
        w.emit   = EM_FLUSH;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[design/cscan_seq.sv]
// ----------------------------------------------------------------------------
// cscan_seq
// Step counter and control store; picks the next step from the jump field.
// ----------------------------------------------------------------------------
module cscan_seq (
  input  logic             clk,
  input  logic             rst,
  input  cscan_pkg::status_t status,
  output cscan_pkg::ctrl_t   ctrl
);
  import cscan_pkg::*;

  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  logic             take;
  logic [StepW-1:0] step_inc;

  assign ctrl     = ucode(step);
  assign step_inc = step + StepW'(1);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:        take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_IF_NOT_RUN:  take = !status.run_acc;
      C_IF_SCANNING: take = status.scanning;
      C_IF_FOUND:    take = status.found;
      C_IF_PHASE1:   take = status.phase1;
      default:       take = 1'b1;
    endcase
    if (status.stall) begin
      step_next = step;
    end else if (take) begin
      step_next = ctrl.target;
    end else begin
      step_next = step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/cscan_dp.sv]
// ----------------------------------------------------------------------------
// cscan_dp
// Request store, min-key scan unit and one-deep output hold buffer.
// ----------------------------------------------------------------------------
module cscan_dp #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cscan_pkg::ctrl_t       ctrl,
  output cscan_pkg::status_t     status,
  input  logic                   in_valid,
  input  logic [1:0]             in_cmd,
  input  logic [15:0]            in_cylinder,
  input  logic                   in_sweep_down,
  output logic                   in_ready,
  input  logic [15:0]            head_cyl,
  input  logic [15:0]            low_cyl,
  input  logic [15:0]            high_cyl,
  output logic                   out_valid,
  output logic [15:0]            out_cylinder,
  output logic                   out_last,
  input  logic                   out_ready
);
  import cscan_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int KW = CylW + AW;

  logic [CylW-1:0] mem [MAX_REQUESTS];
  logic [CylW-1:0] rdata;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   rd_idx;
  logic            rd_vld;
  logic            rd_en;

  logic            run_down;
  logic            phase;
  logic            prev_valid;
  logic [KW-1:0]   prev_key;
  logic            best_valid;
  logic [KW-1:0]   best_key;
  logic [CylW-1:0] best_val;

  logic            hold_valid;
  logic [CylW-1:0] hold_data;

  logic            accepted;
  logic            full;
  logic [KW-1:0]   key;
  logic            want_above;
  logic            in_region;
  logic            better;
  logic            emit_req;
  logic            flush_req;
  logic            slot_free;
  logic [CylW-1:0] emit_val;

  assign in_ready   = ctrl.accept;
  assign accepted   = in_valid && in_ready;
  assign full       = (count >= CW'(MAX_REQUESTS));
  assign rd_en      = ctrl.scan && (idx < count);

  assign key        = {rdata, rd_idx} ^ {KW{run_down}};
  assign want_above = ~(phase ^ run_down);
  assign in_region  = want_above ? (rdata > head_cyl) : (rdata < head_cyl);
  assign better     = in_region && (!prev_valid || key > prev_key) &&
                      (!best_valid || key < best_key);

  assign slot_free  = !out_valid || out_ready;
  assign flush_req  = (ctrl.emit == EM_FLUSH);
  assign emit_req   = (ctrl.emit == EM_BEST) ? best_valid :
                      (ctrl.emit != EM_NONE) && !flush_req;

  always_comb begin
    case (ctrl.emit)
      EM_HEAD:    emit_val = head_cyl;
      EM_BEST:    emit_val = best_val;
      EM_BOUND_A: emit_val = run_down ? low_cyl : high_cyl;
      EM_BOUND_B: emit_val = run_down ? high_cyl : low_cyl;
      default:    emit_val = head_cyl;
    endcase
  end

  assign status.run_acc  = accepted && (in_cmd == CMD_RUN);
  assign status.scanning = (idx < count) || rd_vld;
  assign status.found    = best_valid;
  assign status.phase1   = phase;
  assign status.stall    = (flush_req && !slot_free) ||
                           (emit_req && hold_valid && !slot_free);

  // request store
  always_ff @(posedge clk) begin
    if (accepted && in_cmd == CMD_ADD && !full) begin
      mem[count[AW-1:0]] <= in_cylinder;
    end
    if (rd_en) begin
      rdata <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
      run_down   <= 1'b0;
      phase      <= 1'b0;
      prev_valid <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (accepted) begin
        if (in_cmd == CMD_ADD && !full) begin
          count <= count + CW'(1);
        end else if (in_cmd == CMD_CLEAR) begin
          count <= '0;
        end
        if (in_cmd == CMD_RUN) begin
          run_down <= in_sweep_down;
        end
      end
      if (ctrl.scan_init) begin
        idx        <= '0;
        rd_vld     <= 1'b0;
        best_valid <= 1'b0;
      end
      if (ctrl.scan) begin
        rd_vld <= rd_en;
        if (rd_en) begin
          idx <= idx + CW'(1);
        end
        if (rd_vld && better) begin
          best_valid <= 1'b1;
        end
      end
      if (!status.stall) begin
        if (ctrl.phase_op == PH_START) begin
          phase      <= 1'b0;
          prev_valid <= 1'b0;
        end else if (ctrl.phase_op == PH_NEXT) begin
          phase      <= 1'b1;
          prev_valid <= 1'b0;
        end
        if (ctrl.emit == EM_BEST && best_valid) begin
          prev_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan && rd_en) begin
      rd_idx <= idx[AW-1:0];
    end
    if (ctrl.scan && rd_vld && better) begin
      best_key <= key;
      best_val <= rdata;
    end
    if (!status.stall && ctrl.emit == EM_BEST && best_valid) begin
      prev_key <= best_key;
    end
  end

  // output register fed through a one-deep hold stage so tlast is known
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (flush_req && slot_free) begin
        out_valid  <= hold_valid;
        hold_valid <= 1'b0;
      end else if (emit_req && !status.stall) begin
        hold_valid <= 1'b1;
        if (hold_valid) begin
          out_valid <= 1'b1;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush_req && slot_free) begin
      out_cylinder <= hold_data;
      out_last     <= 1'b1;
    end else if (emit_req && !status.stall) begin
      hold_data <= emit_val;
      if (hold_valid) begin
        out_cylinder <= hold_data;
        out_last     <= 1'b0;
      end
    end
  end

endmodule

[design/cscan_disk_request_order_core.sv]
// ----------------------------------------------------------------------------
// cscan_disk_request_order_core
// C-SCAN service order generator with an APB register port.
//
//   channel   dir  transaction payload
//   s_axis    in   tuser: cmd; tdata: cylinder, sweep_down
//   m_axis    out  tdata: cylinder_out; tlast: last_of_run
//   apb       in   head cylinder, low boundary, high boundary
//
// Add, clear and unused commands are accepted back to back.
// While a run is in progress s_axis_tready stays low. Each pick is one pass
// of init, a read of every stored request from the single-port store, the
// read drain and the pick itself.
// Synchronous reset clears the counters and control; the store is not swept.
// A stalled m_axis holds the sequencer in place; no result is dropped.
// ----------------------------------------------------------------------------
module cscan_disk_request_order_core #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] cylinder, [16] sweep_down
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] cylinder_out
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cscan_pkg::*;

  localparam logic [1:0] REG_HEAD  = 2'd0;
  localparam logic [1:0] REG_FIRST = 2'd1;
  localparam logic [1:0] REG_LAST  = 2'd2;

  logic [15:0] head_cyl;
  logic [15:0] low_cyl;
  logic [15:0] high_cyl;
  logic        wr_en;
  ctrl_t       ctrl;
  status_t     status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_cyl <= 16'd0;
      low_cyl  <= 16'd0;
      high_cyl <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HEAD:  head_cyl <= pwdata[15:0];
        REG_FIRST: low_cyl  <= pwdata[15:0];
        REG_LAST:  high_cyl <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEAD:  prdata = {16'd0, head_cyl};
      REG_FIRST: prdata = {16'd0, low_cyl};
      REG_LAST:  prdata = {16'd0, high_cyl};
      default:   prdata = 32'd0;
    endcase
  end

  cscan_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  cscan_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .in_valid       (s_axis_tvalid),
    .in_cmd         (s_axis_tuser),
    .in_cylinder    (s_axis_tdata[15:0]),
    .in_sweep_down  (s_axis_tdata[16]),
    .in_ready       (s_axis_tready),
    .head_cyl       (head_cyl),
    .low_cyl        (low_cyl),
    .high_cyl       (high_cyl),
    .out_valid      (m_axis_tvalid),
    .out_cylinder   (m_axis_tdata),
    .out_last       (m_axis_tlast),
    .out_ready      (m_axis_tready)
  );

endmodule

[tb/sv/cscan_disk_request_order_core_tb.sv]
// ----------------------------------------------------------------------------
// cscan_disk_request_order_core_tb
// Self-checking testbench for the C-SCAN request order core. Streams add,
// run, clear and unused commands with random gaps and output back-pressure,
// predicts each service order in a scoreboard model and compares every
// output transaction in order. Registers are rewritten over APB while idle.
// ----------------------------------------------------------------------------
module cscan_disk_request_order_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cscan_pkg::*;

  localparam int MAX_REQ     = 32;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int ITEM_TARGET = 250;

  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [3:0] ADDR_HEAD  = 4'd0;
  localparam logic [3:0] ADDR_FIRST = 4'd4;
  localparam logic [3:0] ADDR_LAST  = 4'd8;
  localparam logic [3:0] ADDR_SPARE = 4'd12;

  typedef struct packed {
    logic [15:0] cyl;
    logic        last;
  } stop_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] cylinder, [16] sweep_down
  logic [1:0]  s_axis_tuser = '0;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] cylinder_out
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // scoreboard model state
  logic [15:0] req_mem [MAX_REQ];
  int          req_cnt = 0;
  logic [15:0] head_reg = 16'd0;
  logic [15:0] first_reg = 16'd0;
  logic [15:0] last_reg = 16'hFFFF;

  stop_t service_q [$];
  stop_t exp_stop;
  int    bad_cnt = 0;
  int    cycle_cnt = 0;
  int    items_sent = 0;
  int    src_idle_pct = 0;
  int    sink_stall_pct = 0;
  int    sink_hold = 0;

  cscan_disk_request_order_core #(.MAX_REQUESTS(MAX_REQ)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 4))
      0, 1: return 0;
      2: return 10;
      3: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [15:0] pick_cfg();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_request();
    logic [15:0] v;
    v = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0: v = head_reg;
      1: v = 16'd0;
      2: v = 16'hFFFF;
      3: v = head_reg + 16'($urandom_range(0, 4)) - 16'd2;
      4: if (req_cnt > 0) v = req_mem[$urandom_range(0, req_cnt - 1)];
      default: ;
    endcase
    return v;
  endfunction

  // C-SCAN order: head, sweep side, its boundary, opposite boundary, rest
  function automatic void track_command(input logic [1:0] cmd, input logic [15:0] cyl,
                                        input logic down);
    logic [15:0] ord [MAX_REQ];
    logic [15:0] seq [MAX_REQ + 3];
    logic [15:0] v;
    int          n, i, j, k;
    stop_t       s;
    k = 0;
    case (cmd)
      CMD_ADD: begin
        if (req_cnt < MAX_REQ) begin
          req_mem[req_cnt] = cyl;
          req_cnt++;
        end
      end
      CMD_CLEAR: req_cnt = 0;
      CMD_RUN: begin
        n = req_cnt;
        for (i = 0; i < n; i++) begin
          v = req_mem[i];
          j = i;
          while (j > 0 && ord[j - 1] > v) begin
            ord[j] = ord[j - 1];
            j--;
          end
          ord[j] = v;
        end
        seq[k] = head_reg; k++;
        if (!down) begin
          for (i = 0; i < n; i++)
            if (ord[i] > head_reg) begin seq[k] = ord[i]; k++; end
          seq[k] = last_reg; k++;
          seq[k] = first_reg; k++;
          for (i = 0; i < n; i++)
            if (ord[i] < head_reg) begin seq[k] = ord[i]; k++; end
        end else begin
          for (i = n - 1; i >= 0; i--)
            if (ord[i] < head_reg) begin seq[k] = ord[i]; k++; end
          seq[k] = first_reg; k++;
          seq[k] = last_reg; k++;
          for (i = n - 1; i >= 0; i--)
            if (ord[i] > head_reg) begin seq[k] = ord[i]; k++; end
        end
        for (i = 0; i < k; i++) begin
          s.cyl  = seq[i];
          s.last = (i == k - 1);
          service_q.push_back(s);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      sink_hold = pick_gap(sink_stall_pct);
      m_axis_tready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (service_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected transaction: got cyl %0d last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        exp_stop = service_q.pop_front();
        if (m_axis_tdata !== exp_stop.cyl || m_axis_tlast !== exp_stop.last) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: expected cyl %0d last %0b, got cyl %0d last %0b",
                     exp_stop.cyl, exp_stop.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  task automatic issue_cmd(input logic [1:0] cmd, input logic [15:0] cyl, input logic down);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, down, cyl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_command(cmd, cyl, down);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_HEAD:  head_reg = value;
      ADDR_FIRST: first_reg = value;
      ADDR_LAST:  last_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // empty store, registers at reset values
  task automatic test_reset_values();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    issue_cmd(CMD_RUN, 16'd0, 1'b0);
    issue_cmd(CMD_RUN, 16'hFFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_directed_order();
    src_idle_pct   = 30;
    sink_stall_pct = 30;
    write_reg(ADDR_HEAD, 16'd1000);
    write_reg(ADDR_FIRST, 16'd0);
    write_reg(ADDR_LAST, 16'd4999);
    write_reg(ADDR_SPARE, 16'd7);
    issue_cmd(CMD_ADD, 16'd2000, 1'b0);
    issue_cmd(CMD_ADD, 16'd1000, 1'b1);
    issue_cmd(CMD_ADD, 16'd500, 1'b0);
    issue_cmd(CMD_ADD, 16'd2000, 1'b0);
    issue_cmd(CMD_ADD, 16'd0, 1'b1);
    issue_cmd(CMD_ADD, 16'hFFFF, 1'b0);
    issue_cmd(CMD_ADD, 16'd999, 1'b0);
    issue_cmd(CMD_NOP, 16'hFFFF, 1'b1);
    issue_cmd(CMD_RUN, 16'd0, 1'b0);
    issue_cmd(CMD_RUN, 16'd0, 1'b1);
    wait_drained();
    // store survives the run; a stored 2000 now equals the head
    write_reg(ADDR_HEAD, 16'd2000);
    issue_cmd(CMD_RUN, 16'd0, 1'b0);
    issue_cmd(CMD_CLEAR, 16'h5A5A, 1'b1);
    issue_cmd(CMD_RUN, 16'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    src_idle_pct   = 0;
    sink_stall_pct = 60;
    write_reg(ADDR_HEAD, 16'd0);
    write_reg(ADDR_FIRST, 16'hFFFF);
    write_reg(ADDR_LAST, 16'd0);
    issue_cmd(CMD_ADD, 16'd0, 1'b0);
    issue_cmd(CMD_ADD, 16'd1, 1'b0);
    issue_cmd(CMD_ADD, 16'hFFFF, 1'b1);
    issue_cmd(CMD_RUN, 16'd0, 1'b0);
    issue_cmd(CMD_RUN, 16'd0, 1'b1);
    wait_drained();
    write_reg(ADDR_HEAD, 16'hFFFF);
    issue_cmd(CMD_RUN, 16'd0, 1'b0);
    issue_cmd(CMD_RUN, 16'd0, 1'b1);
    issue_cmd(CMD_CLEAR, 16'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_sequences();
    int reps, k;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      src_idle_pct   = pick_pct();
      sink_stall_pct = pick_pct();
      write_reg(ADDR_HEAD, pick_cfg());
      write_reg(ADDR_FIRST, pick_cfg());
      write_reg(ADDR_LAST, pick_cfg());
      for (reps = $urandom_range(1, 4); reps > 0; reps--) begin
        if ($urandom_range(0, 1) == 0)
          issue_cmd(CMD_CLEAR, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        repeat (k) begin
          if ($urandom_range(0, 19) == 0)
            issue_cmd(CMD_NOP, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
          issue_cmd(CMD_ADD, pick_request(), 1'($urandom_range(0, 1)));
        end
        issue_cmd(CMD_RUN, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0)
          issue_cmd(CMD_RUN, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_order();
    test_register_extremes();
    test_random_sequences();
    wait_drained();
    if (bad_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
